### hw/rtl/pvp_pkg.sv
`timescale 1ns / 1ps
package pvp_pkg;

    localparam int PVP_FRAC_BITS    = 16;
    localparam int PVP_SCREEN_WIDTH = 16;

    // divider geometry: |x*scale| < 2^63, |distance - z| < 2^34
    localparam int PVP_NUM_W = 63;
    localparam int PVP_DEN_W = 34;
    localparam int PVP_REM_W = PVP_DEN_W + 1;
    localparam int PVP_ACC_W = PVP_REM_W + PVP_NUM_W;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_OFFSET_X  = 3'd0,
        CFG_OFFSET_Y  = 3'd1,
        CFG_OFFSET_Z  = 3'd2,
        CFG_SCALE     = 3'd3,
        CFG_DISTANCE  = 3'd4,
        CFG_CANVAS_W  = 3'd5,
        CFG_CANVAS_H  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        t_status            status;
        logic               last_out;
    } t_proj;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] scale_factor;
        logic signed [31:0] view_distance;
        logic [12:0]        canvas_width;
        logic [12:0]        canvas_height;
    } t_cfg;

    // item in flight through the divider row
    typedef struct packed {
        logic [PVP_ACC_W-1:0] acc_x;
        logic [PVP_ACC_W-1:0] acc_y;
        logic [PVP_DEN_W-1:0] den_mag;
        logic                 neg_x;
        logic                 neg_y;
        logic                 zero;
        logic                 last;
    } t_div;

    // one restoring step: remainder in the upper bits, quotient fills the lower
    function automatic logic [PVP_ACC_W-1:0] pvp_div_step(
        input logic [PVP_ACC_W-1:0] acc,
        input logic [PVP_DEN_W-1:0] den
    );
        logic [PVP_ACC_W-1:0] sh;
        logic [PVP_REM_W-1:0] hi;
        logic [PVP_REM_W-1:0] dz;
        sh = {acc[PVP_ACC_W-2:0], 1'b0};
        hi = sh[PVP_ACC_W-1:PVP_NUM_W];
        dz = {1'b0, den};
        if (hi >= dz) begin
            sh[PVP_ACC_W-1:PVP_NUM_W] = hi - dz;
            sh[0] = 1'b1;
        end
        return sh;
    endfunction

endpackage

### hw/rtl/pvp_prep.sv
`timescale 1ns / 1ps
module pvp_prep import pvp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_vertex i_data,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_div    o_data
);
    logic                        r_a_valid, r_b_valid, r_c_valid;
    logic signed [31:0]          r_a_x, r_a_y;
    logic signed [PVP_DEN_W-1:0] r_a_den, r_b_den;
    logic                        r_a_last, r_b_last;
    logic signed [63:0]          r_b_px, r_b_py;
    t_div                        r_c;
    logic signed [PVP_DEN_W-1:0] w_den;
    logic [63:0]                 w_mx, w_my;
    logic [PVP_DEN_W-1:0]        w_dm;

    assign w_den = PVP_DEN_W'($signed(i_cfg.view_distance))
                 - PVP_DEN_W'($signed(i_data.vertex_z))
                 - PVP_DEN_W'($signed(i_cfg.offset_z));
    assign w_mx  = r_b_px[63] ? 64'(-r_b_px) : 64'(r_b_px);
    assign w_my  = r_b_py[63] ? 64'(-r_b_py) : 64'(r_b_py);
    assign w_dm  = r_b_den[PVP_DEN_W-1] ? PVP_DEN_W'(-r_b_den) : PVP_DEN_W'(r_b_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_data.vertex_x;
            r_a_y    <= i_data.vertex_y;
            r_a_den  <= w_den;
            r_a_last <= i_data.last_vertex;
            r_b_px   <= 64'(r_a_x) * 64'(i_cfg.scale_factor);
            r_b_py   <= 64'(r_a_y) * 64'(i_cfg.scale_factor);
            r_b_den  <= r_a_den;
            r_b_last <= r_a_last;
            r_c.acc_x   <= {{PVP_REM_W{1'b0}}, w_mx[PVP_NUM_W-1:0]};
            r_c.acc_y   <= {{PVP_REM_W{1'b0}}, w_my[PVP_NUM_W-1:0]};
            r_c.den_mag <= w_dm;
            r_c.neg_x   <= r_b_px[63] ^ r_b_den[PVP_DEN_W-1];
            r_c.neg_y   <= r_b_py[63] ^ r_b_den[PVP_DEN_W-1];
            r_c.zero    <= (r_b_den == '0);
            r_c.last    <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c;
endmodule

### hw/rtl/pvp_div_cell.sv
`timescale 1ns / 1ps
module pvp_div_cell import pvp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);
    logic r_valid;
    t_div r_data;
    t_div n_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // one quotient bit per axis, divisor and flags ride along
    always_comb begin
        n_data       = i_data;
        n_data.acc_x = pvp_div_step(i_data.acc_x, i_data.den_mag);
        n_data.acc_y = pvp_div_step(i_data.acc_y, i_data.den_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### hw/rtl/pvp_post.sv
`timescale 1ns / 1ps
module pvp_post import pvp_pkg::*; #(
    parameter int FRAC_BITS    = PVP_FRAC_BITS,
    parameter int SCREEN_WIDTH = PVP_SCREEN_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_div  i_data,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_proj o_data
);
    localparam int SUM_W = 66;
    localparam int PIX_W = SUM_W - FRAC_BITS;
    localparam logic signed [PIX_W-1:0] LIM_HI =
        PIX_W'((64'sd1 <<< (SCREEN_WIDTH - 1)) - 64'sd1);
    localparam logic signed [PIX_W-1:0] LIM_LO = -LIM_HI - PIX_W'(1);
    localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((66'd1 << FRAC_BITS) - 66'd1);

    logic                    r_valid_1, r_valid_2;
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic                    r_zero, r_last;
    t_proj                   r_out;
    logic signed [SUM_W-1:0] w_sx, w_sy;
    logic [PIX_W-1:0]        w_rx, w_ry;
    logic                    w_satx, w_saty;

    function automatic logic signed [SUM_W-1:0] f_place(
        input logic [PVP_NUM_W-1:0] q,
        input logic                 neg,
        input logic signed [31:0]   offs,
        input logic [12:0]          size
    );
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] h;
        t = neg ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
        h = $signed(SUM_W'(size[12:1])) <<< FRAC_BITS;
        return t + SUM_W'(offs) + h;
    endfunction

    // truncate toward zero then clamp to the screen range
    function automatic logic [PIX_W:0] f_pix(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] a;
        logic signed [PIX_W-1:0] r;
        a = s[SUM_W-1] ? (s + $signed(ROUND_UP)) : s;
        r = a[SUM_W-1:FRAC_BITS];
        if (r > LIM_HI) begin
            return {1'b1, LIM_HI};
        end else if (r < LIM_LO) begin
            return {1'b1, LIM_LO};
        end
        return {1'b0, r};
    endfunction

    assign w_sx = f_place(i_data.acc_x[PVP_NUM_W-1:0], i_data.neg_x,
                          i_cfg.offset_x, i_cfg.canvas_width);
    assign w_sy = f_place(i_data.acc_y[PVP_NUM_W-1:0], i_data.neg_y,
                          i_cfg.offset_y, i_cfg.canvas_height);
    assign {w_satx, w_rx} = f_pix(r_sx);
    assign {w_saty, w_ry} = f_pix(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_1 <= 1'b0;
            r_valid_2 <= 1'b0;
        end else if (i_en) begin
            r_valid_1 <= i_valid;
            r_valid_2 <= r_valid_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx   <= w_sx;
            r_sy   <= w_sy;
            r_zero <= i_data.zero;
            r_last <= i_data.last;
            r_out.last_out <= r_last;
            if (r_zero) begin
                r_out.screen_x <= '0;
                r_out.screen_y <= '0;
                r_out.status   <= ST_ZERO;
            end else begin
                r_out.screen_x <= w_rx[15:0];
                r_out.screen_y <= w_ry[15:0];
                r_out.status   <= (w_satx || w_saty) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid = r_valid_2;
    assign o_data  = r_out;
endmodule

### hw/rtl/perspective_vertex_projector.sv
`timescale 1ns / 1ps
// channel | signals                                   | moves
// in      | i_in_valid, o_in_ready, i_in_data         | one vertex item
// out     | o_out_valid, i_out_ready, o_out_data      | one projected item
// cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data| one register write
//
// one item per cycle sustained while the skid entry is free; 3 prep stages, 63 divider
// cells (one quotient bit each), 2 post stages, output register
// reset: synchronous active low, valid flags clear and configuration registers return to default values
// stall: the pipeline holds while the output skid entry is full,
// input ready follows the skid entry only
module perspective_vertex_projector import pvp_pkg::*; #(
    parameter int FRAC_BITS    = PVP_FRAC_BITS,
    parameter int SCREEN_WIDTH = PVP_SCREEN_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_vertex     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_proj       o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cfg  r_cfg;
    logic  r_out_valid, r_skid_valid;
    t_proj r_out, r_skid;
    logic  w_en;

    // row of divider cells, index 0 is the prep output
    logic w_cv [PVP_NUM_W+1];
    t_div w_cd [PVP_NUM_W+1];
    logic  w_post_valid;
    t_proj w_post_data;

    // whole pipeline advances while the skid entry is free
    assign w_en        = !r_skid_valid;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.offset_z      <= '0;
            r_cfg.scale_factor  <= 32'sd65536;
            r_cfg.view_distance <= 32'sd327680;
            r_cfg.canvas_width  <= 13'd256;
            r_cfg.canvas_height <= 13'd256;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_X: r_cfg.offset_x      <= i_cfg_data;
                CFG_OFFSET_Y: r_cfg.offset_y      <= i_cfg_data;
                CFG_OFFSET_Z: r_cfg.offset_z      <= i_cfg_data;
                CFG_SCALE:    r_cfg.scale_factor  <= i_cfg_data;
                CFG_DISTANCE: r_cfg.view_distance <= i_cfg_data;
                CFG_CANVAS_W: r_cfg.canvas_width  <= i_cfg_data[12:0];
                CFG_CANVAS_H: r_cfg.canvas_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // denominator, products and magnitudes
    pvp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_cv[0]),
        .o_data  (w_cd[0])
    );

    for (genvar g = 0; g < PVP_NUM_W; g++) begin : g_cell
        pvp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // sign, offsets, truncation and clamp
    pvp_post #(
        .FRAC_BITS    (FRAC_BITS),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv[PVP_NUM_W]),
        .i_data  (w_cd[PVP_NUM_W]),
        .i_cfg   (r_cfg),
        .o_valid (w_post_valid),
        .o_data  (w_post_data)
    );

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_post_valid) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (w_post_valid) begin
            if (!r_out_valid || i_out_ready) begin
                r_out <= w_post_data;
            end else begin
                r_skid <= w_post_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### hw/rtl/pvp_checker.sv
`timescale 1ns / 1ps
module pvp_checker import pvp_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_proj o_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_ZERO)
            |-> (o_out_data.screen_x == 16'sd0 && o_out_data.screen_y == 16'sd0))
        else $error("zero denominator item carries coordinates");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
endmodule

bind perspective_vertex_projector pvp_checker u_pvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### dv/tb.sv
`timescale 1ns / 1ps
module tb import pvp_pkg::*;;

    // expected projections, oldest first
    class proj_scoreboard;
        t_proj pending[$];
        int    n_err;

        function void note_vertex(t_proj p);
            pending.push_back(p);
        endfunction

        function void check_proj(t_proj got);
            t_proj want;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
                got.status !== want.status || got.last_out !== want.last_out) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp x=%0d y=%0d st=%0d l=%0b got x=%0d y=%0d st=%0d l=%0b",
                        want.screen_x, want.screen_y, want.status, want.last_out,
                        got.screen_x, got.screen_y, got.status, got.last_out);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_vertex     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_proj       o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    perspective_vertex_projector u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    proj_scoreboard sb = new();
    t_cfg    cfg;
    bit      quiet;      // no idling in the last part of the run
    bit      hold_out;   // long receiver hold-off
    int      idle_cycles;

    // projection of one axis, 64-bit exact arithmetic
    function automatic longint axis_proj(longint coord, longint den, longint offs,
                                         logic [12:0] size, ref bit sat);
        longint t, s, r;
        t = (coord * longint'(cfg.scale_factor)) / den;
        s = t + offs + longint'(size >> 1) * 65536;
        r = s / 65536;
        if (r > 32767) begin sat = 1; return 32767; end
        if (r < -32768) begin sat = 1; return -32768; end
        return r;
    endfunction

    function automatic t_proj project_vertex(t_vertex v);
        t_proj  p;
        longint den;
        bit     sat;
        sat = 0;
        p = '0;
        p.last_out = v.last_vertex;
        den = longint'(cfg.view_distance) - (longint'(v.vertex_z) + longint'(cfg.offset_z));
        if (den == 0) begin
            p.status = ST_ZERO;
        end else begin
            p.screen_x = 16'(axis_proj(v.vertex_x, den, cfg.offset_x, cfg.canvas_width, sat));
            p.screen_y = 16'(axis_proj(v.vertex_y, den, cfg.offset_y, cfg.canvas_height, sat));
            p.status = sat ? ST_SAT : ST_OK;
        end
        return p;
    endfunction

    // valid drops only for an idle gap, so back to back items keep it high
    task automatic idle_burst();
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_vertex(t_vertex v);
        idle_burst();
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_vertex(project_vertex(v));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET_X: cfg.offset_x      = val;
            CFG_OFFSET_Y: cfg.offset_y      = val;
            CFG_OFFSET_Z: cfg.offset_z      = val;
            CFG_SCALE:    cfg.scale_factor  = val;
            CFG_DISTANCE: cfg.view_distance = val;
            CFG_CANVAS_W: cfg.canvas_width  = val[12:0];
            CFG_CANVAS_H: cfg.canvas_height = val[12:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 20)) - 10) << 16 : 0;
            default: return $urandom;
        endcase
    endfunction

    // mostly modest vertices so that plenty of results land on screen
    function automatic t_vertex rand_vertex();
        t_vertex v;
        if ($urandom_range(0, 3) == 0) begin
            v.vertex_x = rand_word();
            v.vertex_y = rand_word();
            v.vertex_z = rand_word();
        end else begin
            v.vertex_x = 32'(int'($urandom_range(0, 2000000)) - 1000000) * 16;
            v.vertex_y = 32'(int'($urandom_range(0, 2000000)) - 1000000) * 16;
            v.vertex_z = 32'(int'($urandom_range(0, 400)) - 200) << 14;
        end
        if ($urandom_range(0, 15) == 0)   // hit the zero denominator
            v.vertex_z = cfg.view_distance - cfg.offset_z;
        v.last_vertex = 1'($urandom_range(0, 1));
        return v;
    endfunction

    // receiver: random ready bursts, plus the long hold-off
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) sb.check_proj(o_out_data);
        if (hold_out || !i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            idle_cycles <= $urandom_range(1, 16) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item while something is offered or owed
    int stuck;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck <= 0;
        else if (sb.pending.size() == 0 && !i_in_valid && !i_cfg_valid)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > 5000) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_vertex v;
    initial begin
        cfg = '{offset_x: 0, offset_y: 0, offset_z: 0, scale_factor: 65536,
                view_distance: 327680, canvas_width: 256, canvas_height: 256};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero denominator, saturation
        send_vertex('{0, 0, 0, 1'b0});
        send_vertex('{32'h7fff_ffff, 32'h8000_0000, 0, 1'b1});
        send_vertex('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0});
        send_vertex('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1});
        send_vertex('{32'h0001_0000, -32'sh0001_0000, 327680, 1'b0});
        send_vertex('{-32'sh8000, 32'h8000, 327679, 1'b1});
        send_vertex('{32'hffff_ffff, 32'h1, 327681, 1'b0});
        send_vertex('{32'h00ff_0000, -32'sh00ff_0000, -32'sh0010_0000, 1'b1});
        drain();

        // register extremes, odd and zero canvas sizes
        write_reg(CFG_OFFSET_X, 32'h7fff_ffff);
        write_reg(CFG_OFFSET_Y, 32'h8000_0000);
        write_reg(CFG_OFFSET_Z, 32'h8000_0000);
        write_reg(CFG_SCALE, 32'h7fff_ffff);
        write_reg(CFG_DISTANCE, 32'h7fff_ffff);
        write_reg(CFG_CANVAS_W, 32'h1fff);
        write_reg(CFG_CANVAS_H, 0);
        send_vertex('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0});
        send_vertex('{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1});
        send_vertex('{32'h1234_5678, 32'h8765_4321, 32'h8000_0000, 1'b0});
        drain();
        write_reg(CFG_SCALE, 32'h8000_0000);
        write_reg(CFG_DISTANCE, 32'h8000_0000);
        write_reg(CFG_OFFSET_Z, 32'h7fff_ffff);
        write_reg(CFG_CANVAS_W, 1);
        write_reg(CFG_CANVAS_H, 4096);
        send_vertex('{32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b1});
        send_vertex('{32'h1, 32'hffff_ffff, 32'h1, 1'b0});
        drain();

        // random phases with varied settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_OFFSET_X, 0); write_reg(CFG_OFFSET_Y, 0);
                write_reg(CFG_OFFSET_Z, 0); write_reg(CFG_SCALE, 65536);
                write_reg(CFG_DISTANCE, 327680);
                write_reg(CFG_CANVAS_W, 256); write_reg(CFG_CANVAS_H, 256);
            end else begin
                write_reg(CFG_OFFSET_X, $urandom_range(0, 1) ? rand_word() : 0);
                write_reg(CFG_OFFSET_Y, $urandom_range(0, 1) ? rand_word() : 0);
                write_reg(CFG_OFFSET_Z, $urandom_range(0, 1) ? rand_word() : 32'h8000);
                write_reg(CFG_SCALE, $urandom_range(0, 1) ? rand_word() :
                          32'($urandom_range(1, 40)) << 16);
                write_reg(CFG_DISTANCE, $urandom_range(0, 1) ? rand_word() :
                          32'($urandom_range(1, 400)) << 16);
                write_reg(CFG_CANVAS_W, $urandom_range(0, 8191));
                write_reg(CFG_CANVAS_H, $urandom_range(0, 8191));
            end
            if (ph == 3) begin
                // receiver holds off while the sender keeps offering
                fork
                    begin
                        hold_out = 1;
                        repeat (300) @(posedge i_clk);
                        hold_out = 0;
                    end
                join_none
            end
            if (ph == 7) quiet = 1;
            for (int k = 0; k < 240; k++) begin
                v = rand_vertex();
                send_vertex(v);
            end
            drain();
        end

        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
